[hw/rtl/dllm_pkg.sv]
// dllm_pkg: shared constants, action codes and controller/datapath structs
`timescale 1ns / 1ps
`default_nettype none

package dllm_pkg;

	// pool size; index and link widths follow from it
	localparam int NODES  = 64;
	localparam int IDX_W  = $clog2(NODES);
	localparam int LINK_W = IDX_W + 1;
	localparam int ACT_W  = 3;

	// link value that means no node
	localparam logic [LINK_W-1:0] NONE = LINK_W'(NODES);

	// action codes
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TAKE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_UNLINK = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic start;      // capture item, issue link reads
		logic exec_step;  // main link update, head/tail/count commit
		logic link_step;  // write the new node's own links
		logic load_out;   // load the response register
	} dllm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ins_pending;  // captured item is an insert or append
		logic out_busy;     // response register full and stalled
	} dllm_sts_t;

endpackage

`default_nettype wire

[hw/rtl/dllm_ram.sv]
// dllm_ram: generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module dllm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[hw/rtl/dllm_ctrl.sv]
// dllm_ctrl: sequencing state machine for one list action
`timescale 1ns / 1ps
`default_nettype none

module dllm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire dllm_pkg::dllm_sts_t sts,
	output dllm_pkg::dllm_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_LINK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd.start     = 1'b0;
		cmd.exec_step = 1'b0;
		cmd.link_step = 1'b0;
		cmd.load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// insert first rewires the neighbours, then the node itself
				if (sts.ins_pending) begin
					cmd.exec_step = 1'b1;
					state_d       = ST_LINK;
				end else if (!sts.out_busy) begin
					cmd.exec_step = 1'b1;
					cmd.load_out  = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_LINK: begin
				if (!sts.out_busy) begin
					cmd.link_step = 1'b1;
					cmd.load_out  = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[hw/rtl/dllm_dp.sv]
// dllm_dp: link memories, head/tail/count registers and response register
`timescale 1ns / 1ps
`default_nettype none

module dllm_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dllm_pkg::dllm_cmd_t           cmd,
	output dllm_pkg::dllm_sts_t                sts,
	input  wire logic [dllm_pkg::ACT_W-1:0]    action,
	input  wire logic [dllm_pkg::IDX_W-1:0]    node,
	input  wire logic [dllm_pkg::LINK_W-1:0]   after_node,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic      [dllm_pkg::LINK_W-1:0]   taken_node,
	output logic      [dllm_pkg::LINK_W-1:0]   list_count,
	output logic      [dllm_pkg::LINK_W-1:0]   head_node,
	output logic      [dllm_pkg::LINK_W-1:0]   tail_node
);

	localparam int IW = dllm_pkg::IDX_W;
	localparam int LW = dllm_pkg::LINK_W;

	// captured item
	logic [dllm_pkg::ACT_W-1:0] act_q;
	logic [IW-1:0]              node_q;
	logic [LW-1:0]              after_q;

	// list registers
	logic [LW-1:0] head_q, tail_q, count_q;
	logic [LW-1:0] head_d, tail_d, count_d;

	// neighbours kept for the second insert write
	logic [LW-1:0] succ_q, pred_q;

	// response register
	logic          rsp_valid_q;
	logic [LW-1:0] rsp_taken_q, rsp_count_q, rsp_head_q, rsp_tail_q;

	// link memories
	logic          nw_en, pw_en;
	logic [IW-1:0] nw_addr, pw_addr, nr_addr;
	logic [LW-1:0] nw_data, pw_data;
	logic [LW-1:0] nxt_rd, prv_rd;

	logic          is_ins;
	logic [LW-1:0] pred_raw, pred, succ, node_ext, taken_d;
	logic          pred_none;

	assign node_ext  = {{(LW-IW){1'b0}}, node_q};
	assign is_ins    = act_q inside {dllm_pkg::ACT_INSERT, dllm_pkg::ACT_APPEND};
	assign pred_raw  = (act_q == dllm_pkg::ACT_APPEND) ? tail_q : after_q;
	assign pred_none = (pred_raw >= dllm_pkg::NONE);
	assign pred      = pred_none ? dllm_pkg::NONE : pred_raw;
	assign succ      = pred_none ? head_q : nxt_rd;

	// read address chosen from the arriving item
	always_comb begin
		case (action)
			dllm_pkg::ACT_INSERT: nr_addr = after_node[IW-1:0];
			dllm_pkg::ACT_APPEND: nr_addr = tail_q[IW-1:0];
			dllm_pkg::ACT_TAKE:   nr_addr = head_q[IW-1:0];
			default:              nr_addr = node;
		endcase
	end

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		taken_d = dllm_pkg::NONE;
		nw_en   = 1'b0;
		nw_addr = '0;
		nw_data = '0;
		pw_en   = 1'b0;
		pw_addr = '0;
		pw_data = '0;
		if (cmd.exec_step) begin
			case (act_q)
				dllm_pkg::ACT_INSERT, dllm_pkg::ACT_APPEND: begin
					if (!pred_none) begin
						nw_en   = 1'b1;
						nw_addr = pred[IW-1:0];
						nw_data = node_ext;
					end else begin
						head_d = node_ext;
					end
					if (succ < dllm_pkg::NONE) begin
						pw_en   = 1'b1;
						pw_addr = succ[IW-1:0];
						pw_data = node_ext;
					end else begin
						tail_d = node_ext;
					end
					if (count_q < dllm_pkg::NONE) begin
						count_d = count_q + LW'(1);
					end
				end
				dllm_pkg::ACT_TAKE: begin
					if (head_q < dllm_pkg::NONE) begin
						taken_d = head_q;
						head_d  = nxt_rd;
						if (nxt_rd >= dllm_pkg::NONE) begin
							tail_d = dllm_pkg::NONE;
						end else begin
							pw_en   = 1'b1;
							pw_addr = nxt_rd[IW-1:0];
							pw_data = dllm_pkg::NONE;
						end
						if (count_q != '0) begin
							count_d = count_q - LW'(1);
						end
					end
				end
				dllm_pkg::ACT_UNLINK: begin
					if (prv_rd < dllm_pkg::NONE) begin
						nw_en   = 1'b1;
						nw_addr = prv_rd[IW-1:0];
						nw_data = nxt_rd;
					end else begin
						head_d = nxt_rd;
					end
					if (nxt_rd < dllm_pkg::NONE) begin
						pw_en   = 1'b1;
						pw_addr = nxt_rd[IW-1:0];
						pw_data = prv_rd;
					end else begin
						tail_d = prv_rd;
					end
					if (count_q != '0) begin
						count_d = count_q - LW'(1);
					end
				end
				dllm_pkg::ACT_CLEAR: begin
					head_d  = dllm_pkg::NONE;
					tail_d  = dllm_pkg::NONE;
					count_d = '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.link_step) begin
			// new node's own links last, so they win over the neighbour writes
			nw_en   = 1'b1;
			nw_addr = node_q;
			nw_data = succ_q;
			pw_en   = 1'b1;
			pw_addr = node_q;
			pw_data = pred_q;
		end
	end

	dllm_ram #(
		.WIDTH(LW),
		.DEPTH(dllm_pkg::NODES)
	) u_next_ram (
		.clk    (clk),
		.wr_en  (nw_en),
		.wr_addr(nw_addr),
		.wr_data(nw_data),
		.rd_en  (cmd.start),
		.rd_addr(nr_addr),
		.rd_data(nxt_rd)
	);

	dllm_ram #(
		.WIDTH(LW),
		.DEPTH(dllm_pkg::NODES)
	) u_prev_ram (
		.clk    (clk),
		.wr_en  (pw_en),
		.wr_addr(pw_addr),
		.wr_data(pw_data),
		.rd_en  (cmd.start),
		.rd_addr(node),
		.rd_data(prv_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= dllm_pkg::NONE;
			tail_q      <= dllm_pkg::NONE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q   <= action;
			node_q  <= node;
			after_q <= after_node;
		end
		if (cmd.exec_step) begin
			succ_q <= succ;
			pred_q <= pred;
		end
		if (cmd.load_out) begin
			rsp_taken_q <= taken_d;
			rsp_count_q <= count_d;
			rsp_head_q  <= head_d;
			rsp_tail_q  <= tail_d;
		end
	end

	assign sts.ins_pending = is_ins;
	assign sts.out_busy    = rsp_valid_q & rsp_stall;

	assign rsp_valid  = rsp_valid_q;
	assign taken_node = rsp_taken_q;
	assign list_count = rsp_count_q;
	assign head_node  = rsp_head_q;
	assign tail_node  = rsp_tail_q;

endmodule

`default_nettype wire

[hw/rtl/doubly_linked_list_manager.sv]
// doubly_linked_list_manager: top level of the linked list manager over a fixed node pool
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  req     | in        | req_valid/req_stall  | action, node, after_node
//  rsp     | out       | rsp_valid/rsp_stall  | taken_node, list_count, head_node, tail_node
//
//  one action at a time: take, unlink, clear and unused codes run one main update,
//  insert and append add a link write step (two writes into each single-write-port link memory)
//  reset (arst_n low) empties the list; link memories keep no reset and need no sweep
//  the response register lets a new request be taken while a response is stalled;
//  the final step of the next action waits until that response transfer is done
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_manager (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request channel
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic [dllm_pkg::ACT_W-1:0]  action,
	input  wire logic [dllm_pkg::IDX_W-1:0]  node,
	input  wire logic [dllm_pkg::LINK_W-1:0] after_node,
	// response channel
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic      [dllm_pkg::LINK_W-1:0] taken_node,
	output logic      [dllm_pkg::LINK_W-1:0] list_count,
	output logic      [dllm_pkg::LINK_W-1:0] head_node,
	output logic      [dllm_pkg::LINK_W-1:0] tail_node
);

	dllm_pkg::dllm_cmd_t cmd;  // controller commands into the datapath
	dllm_pkg::dllm_sts_t sts;  // datapath status back to the controller

	// state machine: idle, main update, second link write of an insert
	dllm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// next/prev link memories, list head, tail and count, response register
	dllm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.action    (action),
		.node      (node),
		.after_node(after_node),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.taken_node(taken_node),
		.list_count(list_count),
		.head_node (head_node),
		.tail_node (tail_node)
	);

	// a request transfer always starts a busy period
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request transfer not followed by busy controller");

	// a response only appears at the end of an action
	a_rsp_from_action: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response raised without an action in progress");

	// the count saturates at the pool size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (list_count <= dllm_pkg::NONE))
		else $error("list count above pool size");

	// insert holds the controller busy for its second link write
	a_insert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec_step && sts.ins_pending) |=> (req_stall && !cmd.start))
		else $error("insert left before its link write");

endmodule

`default_nettype wire
